### src/fdd_pkg.sv
`default_nettype none
package fdd_pkg;

  // Default schedule length and time width.
  localparam int MAX_JOBS_DEF = 256;
  localparam int TIME_BITS    = 16;

  // Width of one time field on the ports.
  localparam int T_W = 16;
  // Bits of a time value that take part in the arithmetic.
  localparam int TIME_USED = (TIME_BITS < T_W) ? TIME_BITS : T_W;
  localparam logic [T_W-1:0] TIME_MASK = T_W'((33'h1 << TIME_USED) - 33'h1);

  // Fraction bits of an index, and its value for one.
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = FRAC_BITS + 1;
  localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1) << FRAC_BITS;

  // Signed differences and their products.
  localparam int DIF_W  = T_W + 2;
  localparam int PROD_W = 2 * DIF_W;
  // Magnitude of a product or a sum fed to the divider.
  localparam int MAG_W  = 35;

  // Due-date kinds.
  localparam logic DUE_CRISP  = 1'b0;
  localparam logic DUE_LINEAR = 1'b1;

  // Outcome of the rule selection for one job.
  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_ONE,
    CLS_RATIO
  } cls_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RULE,
    ST_MUL_NUM,
    ST_MUL_DEN,
    ST_CHECK,
    ST_DIV,
    ST_ACCUM,
    ST_MEAN_START,
    ST_MEAN_WAIT,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

### src/fdd_divider.sv
`default_nettype none
module fdd_divider #(
  parameter int MAG_W = 35,
  parameter int DVD_W = 26,
  parameter int CNT_W = 5
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [MAG_W-1:0] rem_init,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [MAG_W-1:0] divisor,
  input  wire logic [CNT_W-1:0] steps,
  output logic                  done,
  output logic      [DVD_W-1:0] quotient
);

  logic [MAG_W-1:0] rem;
  logic [DVD_W-1:0] dvd;
  logic [MAG_W-1:0] den;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [MAG_W:0]   shifted;
  logic [MAG_W:0]   diff;
  logic             take;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    shifted = {rem, dvd[DVD_W-1]};
    diff    = shifted - {1'b0, den};
    take    = (shifted >= {1'b0, den});
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder, dividend and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= rem_init;
      dvd      <= dividend;
      den      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= take ? diff[MAG_W-1:0] : shifted[MAG_W-1:0];
      dvd      <= dvd << 1;
      quotient <= {quotient[DVD_W-2:0], take};
    end
  end

endmodule
`default_nettype wire

### src/fuzzy_due_date_agreement_core.sv
`default_nettype none
// Fuzzy due-date agreement core.
// Input stream s_axis: one request per job. tdata holds the triangular
// completion time (low, mid, high) and the due-date points (early, late),
// tuser gives the due-date kind (0 crisp, 1 linear) and tlast closes a
// schedule. The core works out each job's agreement index in Q1.16.
// Output stream m_axis: one request per schedule with the minimum index,
// the mean index, the job count and a flag for any zero divisor.
// A schedule also closes on its own after MAX_JOBS jobs.
// Flow: a job whose index is plainly zero or one skips the products, one
// that the products settle skips the division, and one that needs a
// quotient goes through the divider; the closing job also has the mean
// worked out by the divider before the result is emitted. All
// quotients come from one shift-subtract divider that yields one bit per
// cycle, and all products from one multiplier, numerator then divisor.
// s_axis_tready is high only while the sequencer is idle.
// The result sits in an output register; the core takes the next job while
// it waits, and stalls only when a second result is ready before the
// first one has been taken.
// Reset clears the accumulators (minimum one, sum and count zero) and
// drops m_axis_tvalid.
module fuzzy_due_date_agreement_core #(
  parameter int MAX_JOBS = fdd_pkg::MAX_JOBS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // completion_low, completion_mid, completion_high, due_early, due_late
  input  wire logic [79:0] s_axis_tdata,
  // due_kind
  input  wire logic [0:0]  s_axis_tuser,
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // min_agreement, mean_agreement, jobs_seen, divide_fault, zero padding
  output logic [47:0]      m_axis_tdata
);

  import fdd_pkg::*;

  localparam int CNT_W  = $clog2(MAX_JOBS + 1);
  localparam int SUM_W  = IDX_W + CNT_W;
  localparam int STEP_W = $clog2(SUM_W + 1);

  state_t state, state_next;

  // Latched job.
  logic [T_W-1:0] c1, c2, c3, de, dl;
  logic           kind, last;

  // Rule outcome and operands.
  logic signed [DIF_W-1:0] op_a, op_b1, op_b2;
  logic              op_sq;
  logic signed [PROD_W-1:0] num, den;
  logic signed [PROD_W-1:0] prod;
  logic [IDX_W-1:0]  idx;
  logic              job_fault;

  // Accumulators.
  logic [IDX_W-1:0] run_min;
  logic [SUM_W-1:0] run_sum;
  logic [CNT_W-1:0] run_cnt;
  logic             run_fault;
  logic             closing;
  logic [IDX_W-1:0] mean;

  // Divider hookup.
  logic             div_start;
  logic [MAG_W-1:0] div_rem;
  logic [SUM_W-1:0] div_dvd;
  logic [MAG_W-1:0] div_den;
  logic [STEP_W-1:0] div_steps;
  logic             div_done;
  logic [SUM_W-1:0] div_quot;

  // Rule selection terms.
  logic signed [DIF_W-1:0] s1, s2, s3, se, sl, dd;
  cls_t              r_cls;
  logic signed [DIF_W-1:0] r_a, r_b1, r_b2;
  logic              r_sq;

  // Magnitudes and checks on the products.
  logic [PROD_W-1:0] num_mag, den_mag;
  logic              ratio_zero, ratio_full;

  // Output register.
  logic [IDX_W-1:0] out_min, out_mean;
  logic [8:0]       out_jobs;
  logic             out_fault;
  logic             out_load;

  fdd_divider #(
    .MAG_W(MAG_W),
    .DVD_W(SUM_W),
    .CNT_W(STEP_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem),
    .dividend (div_dvd),
    .divisor  (div_den),
    .steps    (div_steps),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Piecewise rules for both due-date kinds.
  always_comb begin
    s1 = DIF_W'(signed'({1'b0, c1}));
    s2 = DIF_W'(signed'({1'b0, c2}));
    s3 = DIF_W'(signed'({1'b0, c3}));
    se = DIF_W'(signed'({1'b0, de}));
    sl = DIF_W'(signed'({1'b0, dl}));
    dd = (s2 - s1) + (sl - se);
    r_cls = CLS_RATIO;
    r_a   = '0;
    r_b1  = '0;
    r_b2  = DIF_W'(1);
    r_sq  = 1'b0;
    if (kind == DUE_CRISP) begin
      if (s3 <= se) begin
        r_cls = CLS_ONE;
      end else if (s1 >= se) begin
        r_cls = CLS_ZERO;
      end else if (s2 >= se) begin
        r_a  = se - s1;
        r_sq = 1'b1;
        r_b1 = s2 - s1;
        r_b2 = s3 - s1;
      end else begin
        r_a  = se - s1;
        r_b1 = s3 - s1;
      end
    end else begin
      if (s2 <= se && s3 <= sl) begin
        r_cls = CLS_ONE;
      end else if (s1 >= sl) begin
        r_cls = CLS_ZERO;
      end else if (s2 >= se && s3 >= sl) begin
        r_a  = sl - s1;
        r_sq = 1'b1;
        r_b1 = dd;
        r_b2 = s3 - s1;
      end else if (s2 < se && s3 > sl) begin
        r_a  = sl - s1;
        r_b1 = s3 - s1;
      end else begin
        r_a  = sl - s1;
        r_b1 = dd;
      end
    end
  end

  // Shared multiplier: numerator first, then divisor.
  always_comb begin
    if (state == ST_MUL_NUM) begin
      prod = PROD_W'(op_a) * PROD_W'(op_sq ? op_a : DIF_W'(1));
    end else begin
      prod = PROD_W'(op_b1) * PROD_W'(op_b2);
    end
  end

  // Quotient checks before dividing.
  always_comb begin
    num_mag    = num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
    den_mag    = den[PROD_W-1] ? PROD_W'(-den) : PROD_W'(den);
    ratio_zero = (num == '0) || (num[PROD_W-1] != den[PROD_W-1]);
    ratio_full = (num_mag >= den_mag);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) state_next = ST_RULE;
      end
      ST_RULE: begin
        state_next = (r_cls == CLS_RATIO) ? ST_MUL_NUM : ST_ACCUM;
      end
      ST_MUL_NUM: state_next = ST_MUL_DEN;
      ST_MUL_DEN: state_next = ST_CHECK;
      ST_CHECK: begin
        if (den == '0 || ratio_zero || ratio_full) state_next = ST_ACCUM;
        else state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        state_next = closing ? ST_MEAN_START : ST_IDLE;
      end
      ST_MEAN_START: state_next = ST_MEAN_WAIT;
      ST_MEAN_WAIT: begin
        if (div_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    out_load      = (state == ST_EMIT) && (!m_axis_tvalid || m_axis_tready);
    div_start     = 1'b0;
    div_rem       = '0;
    div_dvd       = '0;
    div_den       = '0;
    div_steps     = STEP_W'(FRAC_BITS);
    unique case (state)
      ST_CHECK: begin
        div_start = !(den == '0 || ratio_zero || ratio_full);
        div_rem   = num_mag[MAG_W-1:0];
        div_den   = den_mag[MAG_W-1:0];
      end
      ST_MEAN_START: begin
        div_start = 1'b1;
        div_dvd   = run_sum;
        div_den   = MAG_W'(run_cnt);
        div_steps = STEP_W'(SUM_W);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Job datapath.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_axis_tvalid) begin
      c1   <= s_axis_tdata[15:0]  & TIME_MASK;
      c2   <= s_axis_tdata[31:16] & TIME_MASK;
      c3   <= s_axis_tdata[47:32] & TIME_MASK;
      de   <= s_axis_tdata[63:48] & TIME_MASK;
      dl   <= s_axis_tdata[79:64] & TIME_MASK;
      kind <= s_axis_tuser[0];
      last <= s_axis_tlast;
    end
    case (state)
      ST_RULE: begin
        op_a      <= r_a;
        op_b1     <= r_b1;
        op_b2     <= r_b2;
        op_sq     <= r_sq;
        job_fault <= 1'b0;
        idx       <= (r_cls == CLS_ONE) ? IDX_ONE : '0;
      end
      ST_MUL_NUM: num <= prod;
      ST_MUL_DEN: den <= prod;
      ST_CHECK: begin
        job_fault <= (den == '0);
        idx       <= (den == '0 || ratio_zero) ? '0 : IDX_ONE;
      end
      ST_DIV: begin
        if (div_done) idx <= {1'b0, div_quot[FRAC_BITS-1:0]};
      end
      ST_MEAN_WAIT: begin
        if (div_done) mean <= div_quot[IDX_W-1:0];
      end
      default: begin
        mean <= mean;
      end
    endcase
  end

  // Accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_min   <= IDX_ONE;
      run_sum   <= '0;
      run_cnt   <= '0;
      run_fault <= 1'b0;
      closing   <= 1'b0;
    end else if (state == ST_ACCUM) begin
      if (idx < run_min) run_min <= idx;
      run_sum   <= run_sum + SUM_W'(idx);
      run_cnt   <= run_cnt + CNT_W'(1);
      run_fault <= run_fault | job_fault;
      closing   <= 1'b0;
    end else if (out_load) begin
      run_min   <= IDX_ONE;
      run_sum   <= '0;
      run_cnt   <= '0;
      run_fault <= 1'b0;
    end else if (state == ST_RULE) begin
      closing <= last || ((run_cnt + CNT_W'(1)) >= CNT_W'(MAX_JOBS));
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_min   <= run_min;
      out_mean  <= mean;
      out_jobs  <= 9'(run_cnt);
      out_fault <= run_fault;
    end
  end

  assign m_axis_tdata = {4'b0, out_fault, out_jobs, out_mean, out_min};

endmodule
`default_nettype wire
